// ----- sv/bsct_pkg.sv -----
// Package: shared types, widths and mode codes for the collision test block.
package bsct_pkg;
  localparam int CoordW   = 32;
  localparam int RadW     = 31;
  localparam int IdW      = 10;
  localparam int DistW    = 32;
  localparam int WideW    = 160;

  localparam logic [1:0] MODE_SPHERE = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_BOX    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_A_X    = 3'd1;
  localparam logic [2:0] REG_A_Y    = 3'd2;
  localparam logic [2:0] REG_A_Z    = 3'd3;
  localparam logic [2:0] REG_B_X    = 3'd4;
  localparam logic [2:0] REG_B_Y    = 3'd5;
  localparam logic [2:0] REG_B_Z    = 3'd6;
  localparam logic [2:0] REG_RADIUS = 3'd7;

  typedef struct packed {
    logic [IdW-1:0]    object_id;
    logic signed [CoordW-1:0] cand_center_x;
    logic signed [CoordW-1:0] cand_center_y;
    logic signed [CoordW-1:0] cand_center_z;
    logic [RadW-1:0]   cand_radius;
    logic              test_enabled;
    logic              is_query_object;
    logic              first_of_query;
  } cand_t;

  typedef struct packed {
    logic [IdW-1:0]           hit_object_id;
    logic signed [DistW-1:0]  hit_distance;
  } hit_t;

  // serial multiplier control to datapath
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

// ----- sv/bsct_if.sv -----
// Interface: valid/ready channel carrying one payload beat.
interface bsct_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/bsct_mul.sv -----
// Bit-serial signed multiplier: one multiplier bit per cycle, wide product.
module bsct_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [bsct_pkg::WideW-1:0] a,
  input  logic signed [bsct_pkg::WideW-1:0] b,
  input  logic [7:0]                  nbits,
  output logic                        done,
  output logic [bsct_pkg::WideW-1:0]  prod
);
  import bsct_pkg::*;
  logic [WideW-1:0] mcand;
  logic [WideW-1:0] mplier;
  logic [7:0]       cnt;
  logic             busy;
  logic             neg;

  // multiplies magnitudes, then fixes the sign; nbits bounds the magnitude width
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        neg    <= a[WideW-1] ^ b[WideW-1];
        mcand  <= a[WideW-1] ? -a : a;
        mplier <= b[WideW-1] ? -b : b;
        prod   <= '0;
        cnt    <= nbits;
      end else if (busy) begin
        if (cnt == 8'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) prod <= -prod;
        end else begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 8'd1;
        end
      end
    end
  end
endmodule

// ----- sv/bounding_sphere_collision_test.sv -----
// Throughput: one item at a time; set by the bit-serial multiplier (one bit/cycle),
// the restoring divider (one quotient bit/cycle) and the square root (one digit/cycle).
// Reset: synchronous, active high; control and query registers and generation clear at once.
// After reset a clearing pass writes zero to every mark; no item is taken until it ends.
// Result register drives the output; a new item is taken only when idle and the result has drained.
module bounding_sphere_collision_test #(
  parameter int MAX_OBJECTS = 1024,
  parameter int GEN_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bsct_if.sink   cand,
  bsct_if.source hit
);
  import bsct_pkg::*;
  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_RD = 5'd2,   S_CHK = 5'd3,
                         S_M0 = 5'd4,     S_M1 = 5'd5,    S_M2 = 5'd6,   S_M3 = 5'd7,
                         S_M4 = 5'd8,     S_M5 = 5'd9,    S_M6 = 5'd10,  S_M7 = 5'd11,
                         S_M8 = 5'd12,    S_DEC = 5'd13,  S_DIV = 5'd14, S_SQ = 5'd15,
                         S_OUT = 5'd16,   S_M9 = 5'd17,   S_M10 = 5'd18, S_M11 = 5'd19;

  logic [1:0]  query_mode;
  logic [31:0] qa [3];
  logic [31:0] qb [3];
  logic [30:0] query_radius;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      query_mode <= MODE_SPHERE;
      qa[0] <= '0; qa[1] <= '0; qa[2] <= '0;
      qb[0] <= '0; qb[1] <= '0; qb[2] <= '0;
      query_radius <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_MODE:   query_mode <= pwdata[1:0];
        REG_A_X:    qa[0] <= pwdata;
        REG_A_Y:    qa[1] <= pwdata;
        REG_A_Z:    qa[2] <= pwdata;
        REG_B_X:    qb[0] <= pwdata;
        REG_B_Y:    qb[1] <= pwdata;
        REG_B_Z:    qb[2] <= pwdata;
        REG_RADIUS: query_radius <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:   prdata = {30'd0, query_mode};
      REG_A_X:    prdata = qa[0];
      REG_A_Y:    prdata = qa[1];
      REG_A_Z:    prdata = qa[2];
      REG_B_X:    prdata = qb[0];
      REG_B_Y:    prdata = qb[1];
      REG_B_Z:    prdata = qb[2];
      REG_RADIUS: prdata = {1'b0, query_radius};
      default:    prdata = '0;
    endcase
  end

  // mark store
  logic [GEN_WIDTH-1:0] marks [MAX_OBJECTS];
  logic [GEN_WIDTH-1:0] mark_rd;
  logic                 mark_we;
  logic [AW-1:0]        mark_wa;
  logic [GEN_WIDTH-1:0] mark_wd;
  logic [AW-1:0]        mark_ra;
  always_ff @(posedge clk) begin
    if (mark_we) marks[mark_wa] <= mark_wd;
    mark_rd <= marks[mark_ra];
  end

  logic [4:0]           state;
  logic [AW:0]          clr_cnt;
  logic [GEN_WIDTH-1:0] gen;
  cand_t                c;
  logic                 out_valid;
  hit_t                 out_data;

  // wide datapath registers
  logic signed [WideW-1:0] d0, d1, d2, v0, v1, v2, acc, t0, t1, lenr, cdr, offr;
  logic [WideW-1:0] num, den;
  logic [7:0]   qbit;
  logic [34:0]  q;
  logic [63:0]  sx, sres, sbit;
  logic         negcd;

  logic                 mstart, mdone;
  logic signed [WideW-1:0] ma, mb;
  logic [7:0]           mn;
  logic [WideW-1:0]     mp;
  bsct_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .nbits(mn),
                  .done(mdone), .prod(mp));

  function automatic logic signed [WideW-1:0] sx32(input logic [31:0] x);
    return WideW'(signed'(x));
  endfunction

  wire in_fire = cand.valid && cand.ready;
  assign cand.ready = (state == S_IDLE) && !out_valid;
  wire out_fire = hit.valid && hit.ready;
  assign hit.valid = out_valid;
  assign hit.data  = out_data;
  assign mark_ra   = AW'(c.object_id);

  wire [WideW-1:0] den_sh = den << qbit;

  // per-dimension box distance
  function automatic logic signed [WideW-1:0] boxd(input logic signed [WideW-1:0] cc,
      input logic signed [WideW-1:0] lo, input logic signed [WideW-1:0] hi);
    if (cc < lo) return lo - cc;
    else if (cc > hi) return cc - hi;
    else return '0;
  endfunction

  always_comb begin
    mark_we = 1'b0;
    mark_wa = AW'(c.object_id);
    mark_wd = gen;
    if (state == S_CLEAR) begin
      mark_we = 1'b1;
      mark_wa = clr_cnt[AW-1:0];
      mark_wd = '0;
    end else if (state == S_CHK) begin
      mark_we = (mark_rd != gen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      gen       <= '0;
      out_valid <= 1'b0;
      mstart    <= 1'b0;
    end else begin
      mstart <= 1'b0;
      if (out_fire) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(MAX_OBJECTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_fire) begin
          c <= cand.data;
          if (cand.data.first_of_query) gen <= gen + 1'b1;
          if ({22'd0, cand.data.object_id} >= 32'(MAX_OBJECTS) || !cand.data.test_enabled ||
              query_mode == MODE_NONE ||
              (query_mode == MODE_SPHERE && cand.data.is_query_object))
            state <= S_IDLE;
          else state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (mark_rd == gen) state <= S_IDLE;
          else begin
            if (query_mode == MODE_BOX) begin
              d0 <= boxd(sx32(c.cand_center_x), sx32(qa[0]), sx32(qb[0]));
              d1 <= boxd(sx32(c.cand_center_y), sx32(qa[1]), sx32(qb[1]));
              d2 <= boxd(sx32(c.cand_center_z), sx32(qa[2]), sx32(qb[2]));
            end else if (query_mode == MODE_SPHERE) begin
              d0 <= sx32(qa[0]) - sx32(c.cand_center_x);
              d1 <= sx32(qa[1]) - sx32(c.cand_center_y);
              d2 <= sx32(qa[2]) - sx32(c.cand_center_z);
            end else begin
              d0 <= sx32(qb[0]) - sx32(qa[0]);
              d1 <= sx32(qb[1]) - sx32(qa[1]);
              d2 <= sx32(qb[2]) - sx32(qa[2]);
              v0 <= sx32(c.cand_center_x) - sx32(qa[0]);
              v1 <= sx32(c.cand_center_y) - sx32(qa[1]);
              v2 <= sx32(c.cand_center_z) - sx32(qa[2]);
            end
            state <= S_M0;
          end
        end
        // squared distance (d.d), or line length (dl.dl)
        S_M0: begin ma <= d0; mb <= d0; mn <= 8'd34; mstart <= 1'b1; state <= S_M1; end
        S_M1: if (mdone) begin
          acc <= mp; ma <= d1; mb <= d1; mstart <= 1'b1; state <= S_M2;
        end
        S_M2: if (mdone) begin
          acc <= acc + mp; ma <= d2; mb <= d2; mstart <= 1'b1; state <= S_M3;
        end
        S_M3: if (mdone) begin
          t0 <= acc + mp;
          if (query_mode == MODE_SPHERE) begin
            ma <= WideW'({1'b0, query_radius}) + WideW'({1'b0, c.cand_radius});
            mb <= WideW'({1'b0, query_radius}) + WideW'({1'b0, c.cand_radius});
          end else begin
            ma <= WideW'({1'b0, c.cand_radius});
            mb <= WideW'({1'b0, c.cand_radius});
          end
          mn <= 8'd33; mstart <= 1'b1;
          state <= (query_mode == MODE_LINE) ? S_M5 : S_M4;
        end
        // sphere / box: t0 = dsq, mp = rr
        S_M4: if (mdone) begin
          if (t0 > signed'(mp)) state <= S_IDLE;
          else if (query_mode == MODE_BOX) begin
            out_data.hit_object_id <= c.object_id;
            out_data.hit_distance  <= '0;
            state <= S_OUT;
          end else if (mp == '0) begin
            out_data.hit_object_id <= c.object_id;
            out_data.hit_distance  <= '0;
            state <= S_OUT;
          end else begin
            num <= t0 << 32; den <= mp; qbit <= 8'd32; q <= '0;
            state <= S_DIV;
          end
        end
        // line: t0 = len, mp = rr
        S_M5: if (mdone) begin
          if (t0 == '0) state <= S_IDLE;
          else begin
            lenr <= t0; t1 <= mp;
            ma <= v0; mb <= d0; mn <= 8'd34; mstart <= 1'b1; state <= S_M6;
          end
        end
        S_M6: if (mdone) begin
          acc <= mp; ma <= v1; mb <= d1; mstart <= 1'b1; state <= S_M7;
        end
        S_M7: if (mdone) begin
          acc <= acc + mp; ma <= v2; mb <= d2; mstart <= 1'b1; state <= S_M8;
        end
        S_M8: if (mdone) begin
          cdr <= acc + mp;
          // v.v reuses d registers
          d0 <= v0; d1 <= v1; d2 <= v2;
          ma <= v0; mb <= v0; mstart <= 1'b1; state <= S_M9;
        end
        S_M9: if (mdone) begin
          acc <= mp; ma <= d1; mb <= d1; mstart <= 1'b1; state <= S_M10;
        end
        S_M10: if (mdone) begin
          acc <= acc + mp; ma <= d2; mb <= d2; mstart <= 1'b1; state <= S_M11;
        end
        S_M11: if (mdone) begin
          // vv done; off = rr*len - vv*len + cd*cd
          ma <= (t1 - (acc + mp)); mb <= lenr; mn <= 8'd70; mstart <= 1'b1;
          state <= S_DEC;
          qbit <= 8'd0;
        end
        // S_DEC sequences: off partial, cd*cd, tail test
        S_DEC: if (mdone) begin
          unique case (qbit)
            8'd0: begin
              offr <= mp; ma <= cdr; mb <= cdr; mn <= 8'd70; mstart <= 1'b1; qbit <= 8'd1;
            end
            8'd1: begin
              offr <= offr + mp;
              if (signed'(offr + mp) < 0) state <= S_IDLE;
              else if (cdr < 0) begin
                if (signed'(mp) <= signed'(offr + mp)) qbit <= 8'd3;
                else state <= S_IDLE;
              end else if (cdr > lenr) begin
                ma <= cdr - lenr; mb <= cdr - lenr; mstart <= 1'b1; qbit <= 8'd2;
              end else qbit <= 8'd3;
            end
            8'd2: begin
              if (signed'(mp) <= offr) qbit <= 8'd3;
              else state <= S_IDLE;
            end
            default: ;
          endcase
        end else if (qbit == 8'd3) begin
          negcd <= cdr[WideW-1];
          num   <= (cdr[WideW-1] ? -cdr : cdr) << 16;
          den   <= lenr;
          out_data.hit_object_id <= c.object_id;
          if ((lenr << 31) <= ((cdr[WideW-1] ? -cdr : cdr) << 16)) begin
            out_data.hit_distance <= cdr[WideW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            state <= S_OUT;
          end else begin
            qbit <= 8'd30; q <= '0; state <= S_DIV;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (den_sh <= num) begin
            num <= num - den_sh;
            q   <= q | (35'd1 << qbit);
          end
          if (qbit == 8'd0) begin
            if (query_mode == MODE_SPHERE) begin
              sx <= 64'(q | ((den_sh <= num) ? 35'd1 : 35'd0));
              sres <= '0; sbit <= 64'd1 << 34;
              state <= S_SQ;
            end else begin
              out_data.hit_object_id <= c.object_id;
              out_data.hit_distance <= negcd ?
                -32'(q | ((den_sh <= num) ? 35'd1 : 35'd0)) :
                 32'(q | ((den_sh <= num) ? 35'd1 : 35'd0));
              state <= S_OUT;
            end
          end else qbit <= qbit - 8'd1;
        end
        // digit-by-digit square root, one result bit per cycle
        S_SQ: begin
          if (sbit == '0) begin
            out_data.hit_object_id <= c.object_id;
            out_data.hit_distance  <= sres[31:0];
            state <= S_OUT;
          end else begin
            if (sx >= sres + sbit) begin
              sx   <= sx - (sres + sbit);
              sres <= (sres >> 1) + sbit;
            end else sres <= sres >> 1;
            sbit <= sbit >> 2;
          end
        end
        S_OUT: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit.ready |=> out_valid && $stable(out_data)) else $error("result lost");
  a_clear_no_take: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cand.ready) else $error("ready during clear");
endmodule

// ----- tb/sv/bounding_sphere_collision_test_test.sv -----
// Testbench: self-checking stimulus and hit prediction for the collision test block.
`timescale 1ns / 100ps
module bounding_sphere_collision_test_test;
  import bsct_pkg::*;

  typedef logic signed [WideW-1:0] wide_t;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 1000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsct_if #(.payload_t(cand_t)) cand_ch (clk);
  bsct_if #(.payload_t(hit_t))  hit_ch  (clk);

  bounding_sphere_collision_test u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cand(cand_ch.sink), .hit(hit_ch.source)
  );

  // shadow of the block: query registers, marks, generation
  logic [1:0]               q_mode;
  logic signed [CoordW-1:0] q_a [3];
  logic signed [CoordW-1:0] q_b [3];
  logic [RadW-1:0]          q_rad;
  logic [15:0]              marks [1024];
  logic [15:0]              generation;

  cand_t pending_cands[$];
  hit_t  pending_hits[$];
  int    errors;
  int    tx_gap;
  int    rx_stall;
  int    hold_req, hold_seen;
  bit    no_idle;
  int    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 34;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic wide_t sx(input logic signed [CoordW-1:0] v);
    return wide_t'(v);
  endfunction

  // Predicts whether the candidate hits the query and, if so, the hit beat.
  function automatic bit predict_hit(input cand_t c, output hit_t h);
    wide_t d [3];
    wide_t dl [3];
    wide_t cr, dsq, ssq, len, cd, vv, rr, perp, off, num, diff;
    logic [63:0] q;
    bit hit, neg;
    h = '0;
    if (c.first_of_query) generation = generation + 16'd1;
    if (!c.test_enabled || q_mode == MODE_NONE) return 0;
    if (q_mode == MODE_SPHERE && c.is_query_object) return 0;
    if (marks[c.object_id] == generation) return 0;
    marks[c.object_id] = generation;
    cr = $signed({129'd0, c.cand_radius});
    h.hit_object_id = c.object_id;
    case (q_mode)
      MODE_SPHERE: begin
        d[0] = sx(q_a[0]) - sx(c.cand_center_x);
        d[1] = sx(q_a[1]) - sx(c.cand_center_y);
        d[2] = sx(q_a[2]) - sx(c.cand_center_z);
        dsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        ssq = ($signed({129'd0, q_rad}) + cr) * ($signed({129'd0, q_rad}) + cr);
        if (dsq > ssq) return 0;
        if (ssq == 0) h.hit_distance = '0;
        else h.hit_distance = 32'(int_sqrt(64'((dsq <<< 32) / ssq)));
        return 1;
      end
      MODE_LINE: begin
        for (int i = 0; i < 3; i++) dl[i] = sx(q_b[i]) - sx(q_a[i]);
        d[0] = sx(c.cand_center_x) - sx(q_a[0]);
        d[1] = sx(c.cand_center_y) - sx(q_a[1]);
        d[2] = sx(c.cand_center_z) - sx(q_a[2]);
        len = dl[0] * dl[0] + dl[1] * dl[1] + dl[2] * dl[2];
        if (len == 0) return 0;
        cd = d[0] * dl[0] + d[1] * dl[1] + d[2] * dl[2];
        vv = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        rr = cr * cr;
        perp = vv * len - cd * cd;
        off = rr * len - perp;
        if (off < 0) return 0;
        if (cd < 0) begin
          hit = (cd * cd <= off);
        end else if (cd > len) begin
          diff = cd - len;
          hit = (diff * diff <= off);
        end else begin
          hit = 1;
        end
        if (!hit) return 0;
        neg = (cd < 0);
        num = (neg ? -cd : cd) <<< 16;
        if ((len <<< 31) <= num) begin
          h.hit_distance = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          q = 64'(num / len);
          h.hit_distance = neg ? -q[31:0] : q[31:0];
        end
        return 1;
      end
      default: begin
        d[0] = sx(c.cand_center_x);
        d[1] = sx(c.cand_center_y);
        d[2] = sx(c.cand_center_z);
        // below min measured to min, else above max to max (inverted box as given)
        for (int i = 0; i < 3; i++) begin
          if (d[i] < sx(q_a[i])) d[i] = sx(q_a[i]) - d[i];
          else if (d[i] > sx(q_b[i])) d[i] = d[i] - sx(q_b[i]);
          else d[i] = 0;
        end
        h.hit_distance = '0;
        return (d[0] * d[0] + d[1] * d[1] + d[2] * d[2] <= cr * cr);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // sender: one candidate beat at a time from the pending queue
  always @(posedge clk) begin
    hit_t h;
    if (rst) begin
      cand_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!(cand_ch.valid && !cand_ch.ready)) begin
      if (cand_ch.valid && cand_ch.ready) begin
        if (predict_hit(cand_ch.data, h)) pending_hits.push_back(h);
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        cand_ch.valid <= 1'b0;
      end else if (pending_cands.size() > 0) begin
        cand_ch.data <= pending_cands.pop_front();
        cand_ch.valid <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        cand_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: checks hit beats, random back-pressure
  always @(posedge clk) begin
    hit_t e;
    int r;
    if (rst) begin
      hit_ch.ready <= 1'b0;
      rx_stall <= 0;
      hold_seen <= 0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: unexpected hit id=%0d dist=%0d", $time,
                   hit_ch.data.hit_object_id, hit_ch.data.hit_distance);
          errors++;
        end else begin
          e = pending_hits.pop_front();
          if (e.hit_object_id !== hit_ch.data.hit_object_id) begin
            $display("%0t: hit_object_id expected %0d actual %0d", $time,
                     e.hit_object_id, hit_ch.data.hit_object_id);
            errors++;
          end
          if (e.hit_distance !== hit_ch.data.hit_distance) begin
            $display("%0t: hit_distance expected %0d actual %0d", $time,
                     e.hit_distance, hit_ch.data.hit_distance);
            errors++;
          end
        end
      end
      r = $urandom_range(0, 99);
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        rx_stall <= 3000;
        hit_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        hit_ch.ready <= 1'b0;
      end else if (no_idle || r < 70) begin
        hit_ch.ready <= 1'b1;
      end else begin
        rx_stall <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(20, 80);
        hit_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cand_ch.valid && cand_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:   q_mode = value[1:0];
      REG_A_X:    q_a[0] = value;
      REG_A_Y:    q_a[1] = value;
      REG_A_Z:    q_a[2] = value;
      REG_B_X:    q_b[0] = value;
      REG_B_Y:    q_b[1] = value;
      REG_B_Z:    q_b[2] = value;
      default:    q_rad = value[RadW-1:0];
    endcase
  endtask

  task automatic set_query(input logic [1:0] mode, input logic [31:0] ax, ay, az,
                           input logic [31:0] bx, by, bz, input logic [31:0] rad);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_A_X, ax);
    write_reg(REG_A_Y, ay);
    write_reg(REG_A_Z, az);
    write_reg(REG_B_X, bx);
    write_reg(REG_B_Y, by);
    write_reg(REG_B_Z, bz);
    write_reg(REG_RADIUS, rad);
  endtask

  task automatic add_cand(input int id, input logic [31:0] x, y, z, input logic [30:0] r,
                          input bit en, input bit own, input bit first);
    cand_t c;
    c.object_id = id[IdW-1:0];
    c.cand_center_x = x;
    c.cand_center_y = y;
    c.cand_center_z = z;
    c.cand_radius = r;
    c.test_enabled = en;
    c.is_query_object = own;
    c.first_of_query = first;
    pending_cands.push_back(c);
  endtask

  // idle point between phases; skipped items leave no trace so wait out latency too
  task automatic drain();
    do @(posedge clk);
    while (pending_cands.size() > 0 || cand_ch.valid || pending_hits.size() > 0 ||
           tx_gap > 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] near(input logic signed [31:0] base, input int spread);
    if ($urandom_range(0, 19) == 0) return $urandom();
    return base + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // random queries: mostly well-formed groups on a small id pool
  task automatic random_phase(input logic [1:0] mode, input int n);
    logic signed [31:0] ax, ay, az;
    int spread, id_pool;
    ax = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    ay = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    az = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    spread = 1 << $urandom_range(10, 17);
    set_query(mode, ax, ay, az, near(ax, spread), near(ay, spread), near(az, spread),
              ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, spread));
    id_pool = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      add_cand(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, id_pool),
               near(ax, spread), near(ay, spread), near(az, spread),
               ($urandom_range(0, 19) == 0) ? 31'($urandom())
                                            : 31'($urandom_range(0, spread)),
               $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
               (i == 0) || ($urandom_range(0, 11) == 0));
    end
    drain();
  endtask

  initial begin
    errors = 0;
    hold_req = 0;
    no_idle = 0;
    generation = '0;
    q_mode = MODE_SPHERE;
    q_rad = '0;
    for (int i = 0; i < 3; i++) begin
      q_a[i] = '0;
      q_b[i] = '0;
    end
    foreach (marks[i]) marks[i] = '0;
    cand_ch.valid = 1'b0;
    cand_ch.data = '0;
    hit_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sphere: no query started yet, then skips, repeats and extreme fields
    set_query(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 32'h0000_8000);
    add_cand(1, 0, 0, 0, 31'h10, 1, 0, 0);
    add_cand(1, 32'h100, 0, 0, 31'h10, 1, 0, 1);
    add_cand(1, 32'h100, 0, 0, 31'h10, 1, 0, 0);
    add_cand(2, 0, 0, 0, 31'h10, 0, 0, 0);
    add_cand(3, 0, 0, 0, 31'h10, 1, 1, 0);
    add_cand(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 0, 0);
    add_cand(4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1, 0, 0);
    add_cand(5, 32'h0000_9000, 0, 0, 31'h1000, 1, 0, 0);
    drain();
    // point query: both radii zero
    set_query(MODE_SPHERE, 32'h1234, 32'hFFFF_0000, 32'h55, 0, 0, 0, 0);
    add_cand(6, 32'h1234, 32'hFFFF_0000, 32'h55, 0, 1, 0, 1);
    add_cand(7, 32'h1235, 32'hFFFF_0000, 32'h55, 0, 1, 0, 0);
    drain();
    // line: ahead, behind, beyond, saturating, then zero length
    set_query(MODE_LINE, 0, 0, 0, 32'h10000, 0, 0, 0);
    add_cand(8, 32'h8000, 32'h100, 0, 31'h1000, 1, 1, 1);
    add_cand(9, 32'hFFFF_F000, 0, 0, 31'h2000, 1, 0, 0);
    add_cand(10, 32'h11000, 0, 0, 31'h2000, 1, 0, 0);
    add_cand(11, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 1, 0, 0);
    add_cand(12, 32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 1, 0, 0);
    drain();
    set_query(MODE_LINE, 32'h7FFF_FFFF, 32'h8000_0000, 5, 32'h7FFF_FFFF, 32'h8000_0000, 5,
              31'h7FFF_FFFF);
    add_cand(13, 32'h7FFF_FFFF, 32'h8000_0000, 5, 31'h100, 1, 0, 1);
    drain();
    // box, then inverted box, then the unused mode
    set_query(MODE_BOX, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h10000, 32'h10000,
              32'h10000, 0);
    add_cand(14, 0, 0, 0, 0, 1, 1, 1);
    add_cand(15, 32'h20000, 0, 0, 31'h10000, 1, 0, 0);
    drain();
    set_query(MODE_BOX, 32'h10000, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'hFFFF_0000,
              32'hFFFF_0000, 0);
    add_cand(16, 0, 0, 0, 31'h10000, 1, 0, 1);
    drain();
    set_query(MODE_NONE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
    add_cand(17, 0, 0, 0, 31'h7FFF_FFFF, 1, 0, 1);
    drain();

    // long receiver hold-off while the sender keeps offering beats
    no_idle = 1;
    hold_req = hold_req + 1;
    random_phase(MODE_SPHERE, 60);
    no_idle = 0;
    for (int p = 0; p < 14; p++) begin
      random_phase((p % 13 == 12) ? MODE_NONE : 2'(p % 3), 60);
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/bsct_pkg.sv
sv/bsct_if.sv
sv/bsct_mul.sv
sv/bounding_sphere_collision_test.sv
tb/sv/bounding_sphere_collision_test_test.sv
